/* src/ncpm_pkg.sv */
// ----------------------------------------------------------------------------
// ncpm_pkg
// shared constants, types and input reduction for the cyclic multiplier
// ----------------------------------------------------------------------------
package ncpm_pkg;

  localparam int POLY_LEN = 1024;
  localparam int MOD_Q    = 12289;
  localparam int LANES    = 4;
  localparam int IDX_W    = $clog2(POLY_LEN);
  localparam int CNT_W    = $clog2(POLY_LEN + LANES + 1);
  localparam int COEF_W   = 14;
  localparam int IN_W     = 15;
  localparam int ACC_W    = 2 * COEF_W + CNT_W;
  localparam int LANE_W   = (LANES > 1) ? $clog2(LANES) : 1;

  // lane sum reduction: fold by 2^14 and 2^28 mod q, then reciprocal estimate
  localparam int RED_W    = 27;
  localparam int FOLD_C1  = 4095;
  localparam int FOLD_C2  = 6829;
  localparam int BAR_M    = 10921;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic clr;
    logic acc_en;
  } lane_ctl_t;

  function automatic logic [COEF_W-1:0] reduce_in(input logic [IN_W-1:0] v);
    logic signed [IN_W+1:0] t;
    begin
      t = signed'({{2{v[IN_W-1]}}, v});
      if (t < 0) t = t + (IN_W+2)'(2 * MOD_Q);
      if (t >= (IN_W+2)'(MOD_Q)) t = t - (IN_W+2)'(MOD_Q);
      return t[COEF_W-1:0];
    end
  endfunction

endpackage

/* src/ncpm_ifs.sv */
// ----------------------------------------------------------------------------
// ncpm channel interfaces
// valid/ready channels for request and result transactions
// ----------------------------------------------------------------------------
interface ncpm_in_if import ncpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [IN_W-1:0]   coeff_first;
  logic [IN_W-1:0]   coeff_second;
  modport source (output valid, req_type, coeff_first, coeff_second, input ready);
  modport sink   (input valid, req_type, coeff_first, coeff_second, output ready);
endinterface

interface ncpm_out_if import ncpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] product_coeff;
  logic              is_last;
  logic              product_valid;
  modport source (output valid, product_coeff, is_last, product_valid, input ready);
  modport sink   (input valid, product_coeff, is_last, product_valid, output ready);
endinterface

/* src/ntt_cyclic_poly_multiply.sv */
// ----------------------------------------------------------------------------
// ntt_cyclic_poly_multiply
// cyclic polynomial product mod x^N-1 and q = 12289
// ----------------------------------------------------------------------------
// Load transactions write one reduced coefficient pair each and return nothing;
// after the N-th pair the block computes the exact cyclic convolution with
// LANES multiply-accumulate lanes, each producing one output coefficient, and
// then a reducer folds each lane sum mod q and writes it to a result store.
// The lanes share the single read port of the first operand store, and a read
// may wait for the result channel. Reads return coefficients in index order,
// wrapping after N-1; before a product exists they return zero with product_valid
// low. No transaction is taken while a product is being computed.
// ----------------------------------------------------------------------------
module ntt_cyclic_poly_multiply import ncpm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ncpm_in_if.sink    in_ch,
  ncpm_out_if.source out_ch
);

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_MERGE, S_RD} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  load_cnt_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              have_r;
  logic [CNT_W-1:0]  k0_r;
  logic [IDX_W-1:0]  i_r;
  logic              v1_r, v2_r;
  logic              rd_prod_r;
  logic              out_valid_r;
  logic [COEF_W-1:0] out_coeff_r;
  logic              out_last_r;
  logic              out_pv_r;

  logic              accept, do_load;
  logic [CNT_W-1:0]  load_idx;
  logic [COEF_W-1:0] a_red, b_red;
  logic              issue;
  logic [COEF_W-1:0] a_data, res_data;
  lane_ctl_t         ctl;
  logic [LANES-1:0][ACC_W-1:0] lane_acc;
  logic              mg_start, mg_done, mg_wr;
  logic [IDX_W-1:0]  mg_addr;
  logic [COEF_W-1:0] mg_data;
  logic              res_rd;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign do_load     = accept && (in_ch.req_type == REQ_LOAD);
  assign load_idx    = (load_cnt_r >= CNT_W'(POLY_LEN)) ? '0 : load_cnt_r;
  assign a_red       = reduce_in(in_ch.coeff_first);
  assign b_red       = reduce_in(in_ch.coeff_second);
  assign issue       = (state_r == S_MAC);
  assign ctl.clr     = issue && (i_r == '0);
  assign ctl.acc_en  = v2_r;
  assign mg_start    = (state_r == S_DRAIN) && !v1_r && !v2_r;
  assign res_rd      = accept && (in_ch.req_type == REQ_READ) && have_r;

  ncpm_ram #(.WIDTH(COEF_W), .DEPTH(POLY_LEN)) u_a_ram (
    .clk, .wr_en(do_load), .wr_addr(load_idx[IDX_W-1:0]), .wr_data(a_red),
    .rd_en(issue), .rd_addr(i_r), .rd_data(a_data)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [CNT_W-1:0] s, j;
    always_comb begin
      s = k0_r + CNT_W'(l);
      if (s >= CNT_W'(POLY_LEN)) s = s - CNT_W'(POLY_LEN);
      if (s >= CNT_W'(i_r)) j = s - CNT_W'(i_r);
      else j = s + CNT_W'(POLY_LEN) - CNT_W'(i_r);
    end
    ncpm_lane u_lane (
      .clk, .wr_en(do_load), .wr_addr(load_idx[IDX_W-1:0]), .wr_data(b_red),
      .rd_en(issue), .rd_addr(j[IDX_W-1:0]), .a_data, .ctl, .acc(lane_acc[l])
    );
  end

  ncpm_merge u_merge (
    .clk, .rst_n, .start(mg_start), .base(k0_r), .lane_acc,
    .done(mg_done), .wr_en(mg_wr), .wr_addr(mg_addr), .wr_data(mg_data)
  );

  ncpm_ram #(.WIDTH(COEF_W), .DEPTH(POLY_LEN)) u_res_ram (
    .clk, .wr_en(mg_wr), .wr_addr(mg_addr), .wr_data(mg_data),
    .rd_en(res_rd), .rd_addr(rd_idx_r), .rd_data(res_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_cnt_r  <= '0;
      rd_idx_r    <= '0;
      have_r      <= 1'b0;
      k0_r        <= '0;
      i_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      rd_prod_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      if (out_valid_r && out_ch.ready && (state_r != S_RD)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (do_load) begin
            load_cnt_r <= load_idx + 1'b1;
            if (load_idx == '0) begin
              have_r   <= 1'b0;
              rd_idx_r <= '0;
            end
            if (load_idx == CNT_W'(POLY_LEN - 1)) begin
              state_r <= S_MAC;
              k0_r    <= '0;
              i_r     <= '0;
            end
          end else if (accept) begin
            rd_prod_r <= have_r;
            state_r   <= S_RD;
          end
        end
        S_MAC: begin
          if (i_r == IDX_W'(POLY_LEN - 1)) begin
            state_r <= S_DRAIN;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (mg_start) state_r <= S_MERGE;
        end
        S_MERGE: begin
          if (mg_done) begin
            if (k0_r + CNT_W'(LANES) >= CNT_W'(POLY_LEN)) begin
              have_r   <= 1'b1;
              rd_idx_r <= '0;
              state_r  <= S_IDLE;
            end else begin
              k0_r    <= k0_r + CNT_W'(LANES);
              i_r     <= '0;
              state_r <= S_MAC;
            end
          end
        end
        S_RD: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_pv_r    <= rd_prod_r;
            out_coeff_r <= rd_prod_r ? res_data : '0;
            out_last_r  <= rd_prod_r && (rd_idx_r == IDX_W'(POLY_LEN - 1));
            if (rd_prod_r) begin
              rd_idx_r <= (rd_idx_r == IDX_W'(POLY_LEN - 1)) ? '0 : rd_idx_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.product_coeff = out_coeff_r;
  assign out_ch.is_last       = out_last_r;
  assign out_ch.product_valid = out_pv_r;

endmodule

/* src/ncpm_ram.sv */
// ----------------------------------------------------------------------------
// ncpm_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ncpm_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

/* src/ncpm_lane.sv */
// ----------------------------------------------------------------------------
// ncpm_lane
// one convolution lane: private copy of the second operand, multiply, accumulate
// ----------------------------------------------------------------------------
module ncpm_lane import ncpm_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [COEF_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  input  logic [COEF_W-1:0] a_data,
  input  lane_ctl_t         ctl,
  output logic [ACC_W-1:0]  acc
);

  logic [COEF_W-1:0]   b_data;
  logic [2*COEF_W-1:0] prod_r;
  logic [ACC_W-1:0]    acc_r;

  ncpm_ram #(.WIDTH(COEF_W), .DEPTH(POLY_LEN)) u_b_ram (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_en, .rd_addr, .rd_data(b_data)
  );

  always_ff @(posedge clk) begin
    prod_r <= a_data * b_data;
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

/* src/ncpm_merge.sv */
// ----------------------------------------------------------------------------
// ncpm_merge
// reduces each lane sum mod q and writes it to the result store
// ----------------------------------------------------------------------------
module ncpm_merge import ncpm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [CNT_W-1:0]            base,
  input  logic [LANES-1:0][ACC_W-1:0] lane_acc,
  output logic                        done,
  output logic                        wr_en,
  output logic [IDX_W-1:0]            wr_addr,
  output logic [COEF_W-1:0]           wr_data
);

  typedef enum logic [2:0] {S_IDLE, S_FOLD, S_EST, S_SUB, S_WR, S_DONE} state_t;

  state_t                  state_r;
  logic [LANE_W-1:0]       ln_r;
  logic [CNT_W-1:0]        k_r;
  logic [RED_W-1:0]        y_r;
  logic [COEF_W-1:0]       qh_r;
  logic [COEF_W:0]         r_r;
  logic [ACC_W-1:0]        cur;
  logic [RED_W-1:0]        fold;
  logic [RED_W+COEF_W-1:0] est;
  logic [RED_W-1:0]        diff;
  logic [COEF_W-1:0]       fin;

  assign cur  = lane_acc[ln_r];
  assign fold = RED_W'(cur[ACC_W-1:2*COEF_W]) * RED_W'(FOLD_C2)
              + RED_W'(cur[2*COEF_W-1:COEF_W]) * RED_W'(FOLD_C1)
              + RED_W'(cur[COEF_W-1:0]);
  assign est  = (RED_W+COEF_W)'(y_r) * (RED_W+COEF_W)'(BAR_M);
  assign diff = y_r - RED_W'(qh_r) * RED_W'(MOD_Q);
  assign fin  = (r_r >= (COEF_W+1)'(MOD_Q)) ? COEF_W'(r_r - (COEF_W+1)'(MOD_Q))
                                            : r_r[COEF_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wr_en   <= 1'b0;
      done    <= 1'b0;
      ln_r    <= '0;
    end else begin
      wr_en <= (state_r == S_WR) && (k_r < CNT_W'(POLY_LEN));
      done  <= (state_r == S_DONE);
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_FOLD;
            ln_r    <= '0;
            k_r     <= base;
          end
        end
        S_FOLD: begin
          y_r     <= fold;
          state_r <= S_EST;
        end
        S_EST: begin
          qh_r    <= est[RED_W+COEF_W-1:RED_W];
          state_r <= S_SUB;
        end
        S_SUB: begin
          r_r     <= diff[COEF_W:0];
          state_r <= S_WR;
        end
        S_WR: begin
          wr_addr <= k_r[IDX_W-1:0];
          wr_data <= fin;
          k_r     <= k_r + 1'b1;
          if (ln_r == LANE_W'(LANES - 1)) begin
            state_r <= S_DONE;
          end else begin
            ln_r    <= ln_r + 1'b1;
            state_r <= S_FOLD;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* verif/ncpm_checker.sv */
// ----------------------------------------------------------------------------
// ncpm_checker
// watches both channels, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module ncpm_checker import ncpm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  ncpm_in_if    in_ch,
  ncpm_out_if   out_ch,
  output int    fail_count,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COEF_W-1:0] coeff;
    logic              last;
    logic              pvalid;
  } product_rsp_t;

  logic [COEF_W-1:0] first_mem [POLY_LEN];
  logic [COEF_W-1:0] second_mem [POLY_LEN];
  int                pairs_loaded;
  int                next_read;
  bit                product_ready;
  product_rsp_t      expected_q [$];

  function automatic logic [COEF_W-1:0] mod_q_of(input logic [IN_W-1:0] raw);
    int v;
    v = int'(signed'(raw));
    v = ((v % MOD_Q) + MOD_Q) % MOD_Q;
    return COEF_W'(v);
  endfunction

  task automatic convolve();
    logic [COEF_W-1:0] acc_res [POLY_LEN];
    longint acc;
    int j;
    for (int k = 0; k < POLY_LEN; k++) begin
      acc = 0;
      for (int i = 0; i < POLY_LEN; i++) begin
        j = (k >= i) ? k - i : k + POLY_LEN - i;
        acc += longint'(first_mem[i]) * longint'(second_mem[j]);
      end
      acc_res[k] = COEF_W'(acc % MOD_Q);
    end
    first_mem = acc_res;
  endtask

  always @(posedge clk) begin
    product_rsp_t rsp;
    if (!rst_n) begin
      pairs_loaded  = 0;
      next_read     = 0;
      product_ready = 0;
      fail_count    = 0;
      expected_q.delete();
      pending       = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction coeff=%0d", out_ch.product_coeff);
          fail_count++;
        end else begin
          rsp = expected_q.pop_front();
          if (out_ch.product_coeff !== rsp.coeff) begin
            $error("product_coeff expected %0d actual %0d", rsp.coeff, out_ch.product_coeff);
            fail_count++;
          end
          if (out_ch.is_last !== rsp.last) begin
            $error("is_last expected %0d actual %0d", rsp.last, out_ch.is_last);
            fail_count++;
          end
          if (out_ch.product_valid !== rsp.pvalid) begin
            $error("product_valid expected %0d actual %0d", rsp.pvalid,
                   out_ch.product_valid);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.req_type == REQ_LOAD) begin
          if (pairs_loaded >= POLY_LEN) pairs_loaded = 0;
          if (pairs_loaded == 0) begin
            product_ready = 0;
            next_read     = 0;
          end
          first_mem[pairs_loaded]  = mod_q_of(in_ch.coeff_first);
          second_mem[pairs_loaded] = mod_q_of(in_ch.coeff_second);
          pairs_loaded++;
          if (pairs_loaded == POLY_LEN) begin
            convolve();
            product_ready = 1;
            next_read     = 0;
          end
        end else if (!product_ready) begin
          rsp = '0;
          expected_q = {expected_q, rsp};
        end else begin
          rsp.coeff  = first_mem[next_read];
          rsp.last   = (next_read == POLY_LEN - 1);
          rsp.pvalid = 1'b1;
          expected_q = {expected_q, rsp};
          next_read = (next_read + 1) % POLY_LEN;
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

/* verif/ntt_cyclic_poly_multiply_tb.sv */
// ----------------------------------------------------------------------------
// ntt_cyclic_poly_multiply_tb
// loads a full coefficient set with extreme and random values, reads part of the
// product back, starts a new set and lets the checker judge every result
// ----------------------------------------------------------------------------
module ntt_cyclic_poly_multiply_tb;
  import ncpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count;
  int   pending;
  bit   quiet_mode = 0;
  int   ready_stall = 0;
  int   cycle_count = 0;

  ncpm_in_if  in_ch ();
  ncpm_out_if out_ch ();

  ntt_cyclic_poly_multiply u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  ncpm_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else if (ready_stall > 0) begin
      ready_stall--;
      out_ch.ready <= (ready_stall == 0);
    end else if (out_ch.valid && out_ch.ready && !quiet_mode) begin
      ready_stall = $urandom_range(0, 10);
      out_ch.ready <= (ready_stall == 0);
    end else begin
      out_ch.ready <= 1;
    end
  end

  task automatic send_item(input logic req, input logic [IN_W-1:0] a,
                           input logic [IN_W-1:0] b);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1;
    in_ch.req_type     <= req;
    in_ch.coeff_first  <= a;
    in_ch.coeff_second <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [IN_W-1:0] draw_coeff();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return IN_W'($urandom);
    if (r == 1) return IN_W'(12288);
    if (r == 2) return IN_W'(-12288);
    return IN_W'($urandom_range(0, 24576) - 12288);
  endfunction

  task automatic read_run(input int count);
    for (int i = 0; i < count; i++) begin
      if ((i % 150) == 0) quiet_mode = ($urandom_range(0, 3) == 0);
      send_item(REQ_READ, IN_W'($urandom), IN_W'($urandom));
    end
  endtask

  initial begin
    in_ch.valid        = 0;
    in_ch.req_type     = REQ_LOAD;
    in_ch.coeff_first  = '0;
    in_ch.coeff_second = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // reads with no product yet, then extreme loads
    read_run(4);
    send_item(REQ_LOAD, IN_W'(12288), IN_W'(-12288));
    send_item(REQ_LOAD, IN_W'(-12288), IN_W'(12288));
    send_item(REQ_LOAD, IN_W'(16383), IN_W'(-16384));
    send_item(REQ_LOAD, IN_W'(-1), IN_W'(0));
    send_item(REQ_LOAD, IN_W'(12289), IN_W'(-12289));
    send_item(REQ_LOAD, IN_W'(0), IN_W'(1));
    send_item(REQ_READ, IN_W'(0), IN_W'(0));
    for (int i = 6; i < POLY_LEN; i++)
      send_item(REQ_LOAD, draw_coeff(), draw_coeff());
    read_run(60);
    // drain completely before the next set
    in_ch.valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
    // a new set drops the finished product
    for (int i = 0; i < 10; i++)
      send_item(REQ_LOAD, draw_coeff(), draw_coeff());
    read_run(5);
    in_ch.valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
src/ncpm_pkg.sv
src/ncpm_ifs.sv
src/ncpm_ram.sv
src/ncpm_lane.sv
src/ncpm_merge.sv
src/ntt_cyclic_poly_multiply.sv
verif/ncpm_checker.sv
verif/ntt_cyclic_poly_multiply_tb.sv
